@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the RTL files; only the request queue uses them.
// Define ASSERT_OFF to compile every check away.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The condition must never hold while out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

`else

`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/jsu_pkg.sv @@
// ---------------------------------------------------------------------------
// jsu_pkg
// Types, character codes and helper functions of the JSON string unescaper.
// ---------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  localparam int JSU_QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [15:0] SURR_HI_MIN = 16'hD800;
  localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
  localparam logic [31:0] SURR_LO_BASE = 32'h0000_DC00;
  localparam logic [31:0] SUPP_BASE    = 32'h0001_0000;

  // One request for the back end: an optional code point to be encoded as
  // UTF-8 (ncp bytes, zero for none) followed by an optional tail result,
  // which is either a plain byte or the string-done marker.
  typedef struct packed {
    logic [2:0]  ncp;
    logic [31:0] cp;
    logic        tail_en;
    logic        tail_done;
    logic [7:0]  tail_byte;
  } jsu_job_t;

  function automatic logic [3:0] hex_of(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
    end
    return v;
  endfunction

  function automatic logic [2:0] utf8_len(input logic [31:0] cp);
    logic [2:0] n;
    if (cp <= 32'h7F) begin
      n = 3'd1;
    end else if (cp <= 32'h7FF) begin
      n = 3'd2;
    end else if (cp <= 32'hFFFF) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  // Result byte of a simple escape; anything unknown passes through.
  function automatic logic [7:0] esc_byte(input logic [7:0] c);
    logic [7:0] b;
    case (c)
      CH_B:    b = 8'h08;
      CH_F:    b = 8'h0C;
      CH_N:    b = 8'h0A;
      CH_R:    b = 8'h0D;
      CH_T:    b = 8'h09;
      default: b = c;
    endcase
    return b;
  endfunction

  // Surrogate pair join, wrapping at 32 bits like the unsigned arithmetic
  // it mirrors (a low half below 0xDC00 wraps round).
  function automatic logic [31:0] join_pair(input logic [15:0] hi, input logic [15:0] lo);
    logic [31:0] hi_off;
    logic [31:0] lo_off;
    hi_off = ({16'd0, hi} - {16'd0, SURR_HI_MIN}) << 10;
    lo_off = {16'd0, lo} - SURR_LO_BASE;
    return SUPP_BASE + hi_off + lo_off;
  endfunction

endpackage

`default_nettype wire

@@ hdl/jsu_front.sv @@
// ---------------------------------------------------------------------------
// jsu_front
// Escape parser: tracks the string and escape state, one byte per cycle while
// the queue has room, and turns each byte with results into a queue request.
// ---------------------------------------------------------------------------
`default_nettype none

module jsu_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_char_byte,
  input  wire logic             in_end_of_text,
  input  wire logic             q_full,
  output logic                  q_push,
  output jsu_pkg::jsu_job_t     q_job
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    M_OUTSIDE = 3'd0,
    M_NORMAL  = 3'd1,
    M_ESCAPE  = 3'd2,
    M_HEX     = 3'd3,
    M_SURR    = 3'd4,
    M_AWAIT_U = 3'd5,
    M_LOW_HEX = 3'd6
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [15:0] hex_value_r, hex_value_nxt;
  logic [2:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] high_surr_r, high_surr_nxt;

  logic        accept;
  logic [15:0] digit_val;
  logic [2:0]  digit_cnt;
  logic        cp_en;
  logic [31:0] cp_val;
  logic        do_norm;
  logic        do_esc;
  jsu_job_t    job;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign digit_val = {hex_value_r[11:0], hex_of(in_char_byte)};
  assign digit_cnt = hex_cnt_r + 3'd1;

  always_comb begin
    mode_nxt      = mode_r;
    hex_value_nxt = hex_value_r;
    hex_cnt_nxt   = hex_cnt_r;
    high_surr_nxt = high_surr_r;
    cp_en         = 1'b0;
    cp_val        = 32'd0;
    do_norm       = 1'b0;
    do_esc        = 1'b0;
    job           = '0;

    if (in_end_of_text) begin
      mode_nxt = M_OUTSIDE;
      case (mode_r)
        M_NORMAL, M_ESCAPE: begin
          job.tail_en   = 1'b1;
          job.tail_done = 1'b1;
        end
        M_HEX: begin
          cp_en         = 1'b1;
          cp_val        = {16'd0, hex_value_r};
          job.tail_en   = 1'b1;
          job.tail_done = 1'b1;
        end
        M_SURR, M_AWAIT_U: begin
          cp_en         = 1'b1;
          cp_val        = {16'd0, high_surr_r};
          job.tail_en   = 1'b1;
          job.tail_done = 1'b1;
        end
        M_LOW_HEX: begin
          cp_en         = 1'b1;
          cp_val        = join_pair(high_surr_r, hex_value_r);
          job.tail_en   = 1'b1;
          job.tail_done = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      case (mode_r)
        M_NORMAL: begin
          do_norm = 1'b1;
        end
        M_ESCAPE: begin
          do_esc = 1'b1;
        end
        M_HEX: begin
          hex_value_nxt = digit_val;
          hex_cnt_nxt   = digit_cnt;
          if (digit_cnt >= 3'd4) begin
            if (digit_val >= SURR_HI_MIN && digit_val <= SURR_HI_MAX) begin
              high_surr_nxt = digit_val;
              mode_nxt      = M_SURR;
            end else begin
              cp_en    = 1'b1;
              cp_val   = {16'd0, digit_val};
              mode_nxt = M_NORMAL;
            end
          end
        end
        M_SURR: begin
          if (in_char_byte == CH_BSLASH) begin
            mode_nxt = M_AWAIT_U;
          end else begin
            cp_en   = 1'b1;
            cp_val  = {16'd0, high_surr_r};
            do_norm = 1'b1;
          end
        end
        M_AWAIT_U: begin
          if (in_char_byte == CH_U) begin
            hex_value_nxt = 16'd0;
            hex_cnt_nxt   = 3'd0;
            mode_nxt      = M_LOW_HEX;
          end else begin
            cp_en  = 1'b1;
            cp_val = {16'd0, high_surr_r};
            do_esc = 1'b1;
          end
        end
        M_LOW_HEX: begin
          hex_value_nxt = digit_val;
          hex_cnt_nxt   = digit_cnt;
          if (digit_cnt >= 3'd4) begin
            cp_en    = 1'b1;
            cp_val   = join_pair(high_surr_r, digit_val);
            mode_nxt = M_NORMAL;
          end
        end
        default: begin
          // The opening quote, or whatever byte stands in its place.
          mode_nxt = M_NORMAL;
        end
      endcase

      if (do_norm) begin
        mode_nxt = M_NORMAL;
        if (in_char_byte == CH_QUOTE) begin
          job.tail_en   = 1'b1;
          job.tail_done = 1'b1;
          mode_nxt      = M_OUTSIDE;
        end else if (in_char_byte == CH_BSLASH) begin
          mode_nxt = M_ESCAPE;
        end else begin
          job.tail_en   = 1'b1;
          job.tail_byte = in_char_byte;
        end
      end

      if (do_esc) begin
        mode_nxt = M_NORMAL;
        if (in_char_byte == CH_U) begin
          hex_value_nxt = 16'd0;
          hex_cnt_nxt   = 3'd0;
          mode_nxt      = M_HEX;
        end else begin
          job.tail_en   = 1'b1;
          job.tail_byte = esc_byte(in_char_byte);
        end
      end
    end

    job.cp  = cp_val;
    job.ncp = cp_en ? utf8_len(cp_val) : 3'd0;
  end

  assign q_job  = job;
  assign q_push = accept && ((job.ncp != 3'd0) || job.tail_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_OUTSIDE;
      hex_value_r <= 16'd0;
      hex_cnt_r   <= 3'd0;
      high_surr_r <= 16'd0;
    end else if (accept) begin
      mode_r      <= mode_nxt;
      hex_value_r <= hex_value_nxt;
      hex_cnt_r   <= hex_cnt_nxt;
      high_surr_r <= high_surr_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/jsu_job_fifo.sv @@
// ---------------------------------------------------------------------------
// jsu_job_fifo
// Small request queue between the parser and the UTF-8 emitter.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jsu_job_fifo #(
  parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire jsu_pkg::jsu_job_t  push_job,
  input  wire logic               pop,
  output logic                    full,
  output logic                    not_empty,
  output jsu_pkg::jsu_job_t       head_job
);
  import jsu_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  jsu_job_t           slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head_job  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  `ASSERT_NEVER(a_no_push_when_full, clk, rst_n, push && full)
  `ASSERT_NEVER(a_no_pop_when_empty, clk, rst_n, pop && !not_empty)
  `ASSERT_NEVER(a_count_in_range, clk, rst_n, count_r > FULL_CNT)
  `ASSERT_IMPLY(a_ptrs_meet_at_ends, clk, rst_n, (count_r == '0) || full, wr_ptr_r == rd_ptr_r)

endmodule

`default_nettype wire

@@ hdl/jsu_back.sv @@
// ---------------------------------------------------------------------------
// jsu_back
// Emitter: walks the request at the head of the queue one result per cycle
// while the output is not stalled (UTF-8 bytes first, then the tail byte or
// done marker) into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module jsu_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               head_valid,
  input  wire jsu_pkg::jsu_job_t  head_job,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_byte_valid,
  output logic                    out_string_done,
  output logic                    out_last_of_run
);
  import jsu_pkg::*;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       byte_valid_r;
  logic       string_done_r;
  logic       last_of_run_r;
  logic [2:0] idx_r, idx_nxt;

  logic       load_ok;
  logic       emit;
  logic [2:0] total;
  logic       is_last;
  logic       in_cp;
  logic [7:0] cp_byte;
  logic [7:0] res_byte;
  logic       res_valid;
  logic       res_done;

  assign load_ok = !out_valid_r || !out_stall;
  assign emit    = head_valid && load_ok;
  assign total   = head_job.ncp + {2'b00, head_job.tail_en};
  assign is_last = (idx_r == total - 3'd1);
  assign in_cp   = (idx_r < head_job.ncp);
  assign pop     = emit && is_last;
  assign idx_nxt = is_last ? 3'd0 : idx_r + 3'd1;

  // UTF-8 byte at the current index; leading byte carries the length mark.
  always_comb begin
    cp_byte = 8'h00;
    case (head_job.ncp)
      3'd1: begin
        cp_byte = head_job.cp[7:0];
      end
      3'd2: begin
        case (idx_r[1:0])
          2'd0:    cp_byte = 8'hC0 | head_job.cp[13:6];
          default: cp_byte = {2'b10, head_job.cp[5:0]};
        endcase
      end
      3'd3: begin
        case (idx_r[1:0])
          2'd0:    cp_byte = 8'hE0 | head_job.cp[19:12];
          2'd1:    cp_byte = {2'b10, head_job.cp[11:6]};
          default: cp_byte = {2'b10, head_job.cp[5:0]};
        endcase
      end
      3'd4: begin
        case (idx_r[1:0])
          2'd0:    cp_byte = 8'hF0 | head_job.cp[25:18];
          2'd1:    cp_byte = {2'b10, head_job.cp[17:12]};
          2'd2:    cp_byte = {2'b10, head_job.cp[11:6]};
          default: cp_byte = {2'b10, head_job.cp[5:0]};
        endcase
      end
      default: begin
        cp_byte = 8'h00;
      end
    endcase
  end

  always_comb begin
    if (in_cp) begin
      res_byte  = cp_byte;
      res_valid = 1'b1;
      res_done  = 1'b0;
    end else begin
      res_byte  = head_job.tail_byte;
      res_valid = !head_job.tail_done;
      res_done  = head_job.tail_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      if (load_ok) begin
        out_valid_r <= head_valid;
      end
      if (emit) begin
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r    <= res_byte;
      byte_valid_r  <= res_valid;
      string_done_r <= res_done;
      last_of_run_r <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_byte_valid  = byte_valid_r;
  assign out_string_done = string_done_r;
  assign out_last_of_run = last_of_run_r;

endmodule

`default_nettype wire

@@ hdl/json_string_unescape_utf8_top.sv @@
// The request of each taken byte is queued, then emitted into the output register.
// Throughput: one byte per cycle while out_stall is low and each byte gives at most one
// result; a byte with more (up to five) holds the emitter, the queue absorbing the rest.
// Reset: rst_n is synchronous and active low; it returns the parser outside a string
// and empties the queue and the output register.
// ---------------------------------------------------------------------------
// json_string_unescape_utf8_top
// JSON string unescaper with UTF-8 output: parser front end, request queue
// and byte emitter.
// ---------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_top #(
  parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_string_done,
  output logic            out_last_of_run
);
  import jsu_pkg::*;

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_not_empty;
  jsu_job_t q_in_job;
  jsu_job_t q_head_job;

  jsu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_byte   (in_char_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (q_in_job)
  );

  jsu_job_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_in_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (q_head_job)
  );

  jsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_not_empty),
    .head_job        (q_head_job),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_string_done (out_string_done),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

@@ bench/unescape_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// unescape_checker
// Watches both channels of the JSON string unescaper, works out the UTF-8
// bytes and markers that each accepted request must give, and compares every
// accepted result with the oldest one still owed.
// ---------------------------------------------------------------------------
module unescape_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_text,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_byte_valid,
  input  logic       out_string_done,
  input  logic       out_last_of_run,
  output int         mismatch_count,
  output int         outstanding,
  output int         results_checked,
  output int         strings_closed
);
  import jsu_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef enum logic [2:0] {
    MODE_OUTSIDE,
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_HEX,
    MODE_SURR_PENDING,
    MODE_AWAIT_U,
    MODE_LOW_HEX
  } decode_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       done;
    logic       last;
  } unescaped_t;

  decode_mode_t decode_mode;
  logic [15:0]  code_acc;
  logic [2:0]   digits_seen;
  logic [15:0]  pending_high;
  unescaped_t   owed_q[$];
  unescaped_t   step_q[$];
  int           errors_n;
  int           results_n;
  int           closed_n;

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c[3:0];
    // Both letter cases share the low bits; a..f and A..F sit at 1..6.
    if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  function automatic void add_result(input logic [7:0] b, input logic v, input logic d);
    unescaped_t r;
    r = '{data: b, data_valid: v, done: d, last: 1'b0};
    step_q = {step_q, r};
  endfunction

  function automatic void add_data_byte(input logic [7:0] b);
    add_result(b, 1'b1, 1'b0);
  endfunction

  function automatic void add_code_point(input logic [31:0] cp);
    logic [31:0] lead;
    if (cp <= 32'h7F) begin
      add_data_byte(cp[7:0]);
    end else if (cp <= 32'h7FF) begin
      lead = 32'hC0 | (cp >> 6);
      add_data_byte(lead[7:0]);
      add_data_byte({2'b10, cp[5:0]});
    end else if (cp <= 32'hFFFF) begin
      lead = 32'hE0 | (cp >> 12);
      add_data_byte(lead[7:0]);
      add_data_byte({2'b10, cp[11:6]});
      add_data_byte({2'b10, cp[5:0]});
    end else begin
      // A wrapped pair can exceed 21 bits; the lead byte is simply cut to 8.
      lead = 32'hF0 | (cp >> 18);
      add_data_byte(lead[7:0]);
      add_data_byte({2'b10, cp[17:12]});
      add_data_byte({2'b10, cp[11:6]});
      add_data_byte({2'b10, cp[5:0]});
    end
  endfunction

  function automatic logic [31:0] paired_code_point(input logic [15:0] hi, input logic [15:0] lo);
    logic [31:0] upper;
    logic [31:0] lower;
    upper = ({16'h0000, hi} - 32'h0000_D800) << 10;
    lower = {16'h0000, lo} - 32'h0000_DC00;
    return 32'h0001_0000 + upper + lower;
  endfunction

  function automatic void take_plain(input logic [7:0] c);
    if (c == CH_QUOTE) begin
      add_result(8'h00, 1'b0, 1'b1);
      decode_mode = MODE_OUTSIDE;
    end else if (c == CH_BSLASH) begin
      decode_mode = MODE_ESCAPE;
    end else begin
      add_data_byte(c);
    end
  endfunction

  function automatic void take_escaped(input logic [7:0] e);
    decode_mode = MODE_NORMAL;
    case (e)
      CH_B: add_data_byte(8'h08);
      CH_F: add_data_byte(8'h0C);
      CH_N: add_data_byte(8'h0A);
      CH_R: add_data_byte(8'h0D);
      CH_T: add_data_byte(8'h09);
      CH_U: begin
        code_acc    = 16'h0000;
        digits_seen = 3'd0;
        decode_mode = MODE_HEX;
      end
      default: add_data_byte(e);
    endcase
  endfunction

  function automatic void shift_digit(input logic [7:0] c);
    code_acc    = {code_acc[11:0], digit_value(c)};
    digits_seen = digits_seen + 3'd1;
  endfunction

  function automatic void predict_unescape(input logic [7:0] c, input logic eot);
    step_q.delete();
    if (eot) begin
      case (decode_mode)
        MODE_NORMAL, MODE_ESCAPE: add_result(8'h00, 1'b0, 1'b1);
        MODE_HEX: begin
          add_code_point({16'h0000, code_acc});
          add_result(8'h00, 1'b0, 1'b1);
        end
        MODE_SURR_PENDING, MODE_AWAIT_U: begin
          add_code_point({16'h0000, pending_high});
          add_result(8'h00, 1'b0, 1'b1);
        end
        MODE_LOW_HEX: begin
          add_code_point(paired_code_point(pending_high, code_acc));
          add_result(8'h00, 1'b0, 1'b1);
        end
        default: ;
      endcase
      decode_mode = MODE_OUTSIDE;
    end else begin
      case (decode_mode)
        MODE_NORMAL: take_plain(c);
        MODE_ESCAPE: take_escaped(c);
        MODE_HEX: begin
          shift_digit(c);
          if (digits_seen >= 3'd4) begin
            if (code_acc >= SURR_HI_MIN && code_acc <= SURR_HI_MAX) begin
              pending_high = code_acc;
              decode_mode  = MODE_SURR_PENDING;
            end else begin
              add_code_point({16'h0000, code_acc});
              decode_mode = MODE_NORMAL;
            end
          end
        end
        MODE_SURR_PENDING: begin
          if (c == CH_BSLASH) begin
            decode_mode = MODE_AWAIT_U;
          end else begin
            add_code_point({16'h0000, pending_high});
            decode_mode = MODE_NORMAL;
            take_plain(c);
          end
        end
        MODE_AWAIT_U: begin
          if (c == CH_U) begin
            code_acc    = 16'h0000;
            digits_seen = 3'd0;
            decode_mode = MODE_LOW_HEX;
          end else begin
            add_code_point({16'h0000, pending_high});
            take_escaped(c);
          end
        end
        MODE_LOW_HEX: begin
          shift_digit(c);
          if (digits_seen >= 3'd4) begin
            add_code_point(paired_code_point(pending_high, code_acc));
            decode_mode = MODE_NORMAL;
          end
        end
        // The byte after the string has ended is taken as the opening quote.
        default: decode_mode = MODE_NORMAL;
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    owed_q = {owed_q, step_q};
  endfunction

  function automatic void note_mismatch(input string what, input unescaped_t want,
                                        input unescaped_t got);
    errors_n++;
    if (errors_n <= REPORT_LIMIT) begin
      $display("%0t ns: %s: expected byte %02h valid %0b done %0b last %0b",
               $time, what, want.data, want.data_valid, want.done, want.last);
      $display("    got byte %02h valid %0b done %0b last %0b",
               got.data, got.data_valid, got.done, got.last);
    end
  endfunction

  always @(posedge clk) begin
    unescaped_t got;
    unescaped_t want;
    if (!rst_n) begin
      decode_mode  = MODE_OUTSIDE;
      code_acc     = 16'h0000;
      digits_seen  = 3'd0;
      pending_high = 16'h0000;
      owed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{data: out_byte, data_valid: out_byte_valid, done: out_string_done,
                last: out_last_of_run};
        results_n++;
        if (out_string_done === 1'b1) closed_n++;
        if (owed_q.size() == 0) begin
          note_mismatch("result with nothing owed", '0, got);
        end else begin
          want = owed_q.pop_front();
          if (got !== want) note_mismatch("result mismatch", want, got);
        end
      end
      if (in_valid && !in_stall) predict_unescape(in_char_byte, in_end_of_text);
    end
    mismatch_count  <= errors_n;
    outstanding     <= owed_q.size();
    results_checked <= results_n;
    strings_closed  <= closed_n;
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Drives JSON text into the string unescaper: a few hand-picked strings for
// the awkward escape and surrogate cases, then random strings built from
// plain bytes, escapes and \u sequences, with noise and early ends mixed in.
// Both channels idle at random; the receiver also holds off for a long
// stretch so that the internal queue fills. The checker does the comparing.
// ---------------------------------------------------------------------------
module tb;
  import jsu_pkg::*;

  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam int         IDLE_PERCENT = 26;
  localparam int         RANDOM_ITEMS = 300;
  localparam int         HOLD_CYCLES  = 80;
  localparam int         DRAIN_CYCLES = 20;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_byte;
  logic       in_end_of_text;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_string_done;
  logic       out_last_of_run;

  int mismatch_count;
  int outstanding;
  int results_checked;
  int strings_closed;

  int          items_sent  = 0;
  bit          calm        = 1'b0;
  bit          hold_wanted = 1'b0;
  logic [7:0]  text_q[$];

  json_string_unescape_utf8_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_byte    (in_char_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_string_done (out_string_done),
    .out_last_of_run (out_last_of_run)
  );

  unescape_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_byte    (in_char_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_string_done (out_string_done),
    .out_last_of_run (out_last_of_run),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .strings_closed  (strings_closed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400us;
    $display("Timed out with %0d results still owed.", outstanding);
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off on request.
  initial begin : receiver
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !hold_used) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [7:0] c, input logic eot);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_char_byte   <= c;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_chars(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic void append_char(input logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    // Now and then a letter outside the hex set, which must decode as zero.
    if ($urandom_range(99) < 5) return 8'($urandom_range(8'h7A, 8'h67));
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    if ($urandom_range(1) == 0) return 8'h57 + 8'(nib);
    return 8'h37 + 8'(nib);
  endfunction

  function automatic void put_u_escape(input logic [15:0] code);
    append_char(CH_BSLASH);
    append_char(CH_U);
    for (int i = 3; i >= 0; i--) append_char(hex_char(code[i*4 +: 4]));
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(9))
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      7: return CH_T;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [15:0] random_code_unit();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'h007F));
      1: return 16'($urandom_range(16'h07FF, 16'h0080));
      2: return 16'($urandom);
      default: return 16'($urandom_range(16'hDBFF, 16'hD800));
    endcase
  endfunction

  function automatic logic [15:0] high_surrogate();
    return 16'($urandom_range(16'hDBFF, 16'hD800));
  endfunction

  // One string: mostly closed by a quote, sometimes cut short by the end of
  // the text, possibly in the middle of an escape.
  task automatic send_random_string();
    int pieces;
    int cut;
    int ending;
    text_q.delete();
    append_char(($urandom_range(9) == 0) ? 8'($urandom) : CH_QUOTE);
    pieces = $urandom_range(6);
    repeat (pieces) begin
      case ($urandom_range(9))
        0, 1, 2, 3: append_char(plain_char());
        4, 5: begin
          append_char(CH_BSLASH);
          append_char(pick_escape());
        end
        6, 7: put_u_escape(random_code_unit());
        8: begin
          put_u_escape(high_surrogate());
          put_u_escape(($urandom_range(4) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(16'hDFFF, 16'hDC00)));
        end
        default: begin
          put_u_escape(high_surrogate());
          if ($urandom_range(1) == 0) begin
            append_char(CH_BSLASH);
            append_char(pick_escape());
          end else begin
            append_char(plain_char());
          end
        end
      endcase
    end
    ending = $urandom_range(99);
    if (ending < 75) append_char(CH_QUOTE);
    cut = (ending >= 75 && ending < 93) ? $urandom_range(text_q.size()) : text_q.size();
    for (int i = 0; i < cut; i++) send_item(text_q[i], 1'b0);
    if (ending >= 75) send_item(8'($urandom), 1'b1);
    if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b1);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(8, 1)) send_item(8'($urandom), $urandom_range(9) == 0);
  endtask

  initial begin : stimulus
    int first_random;
    int strings_sent;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_char_byte   = 8'h00;
    in_end_of_text = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // End of text while outside any string gives nothing.
    send_item(8'hA5, 1'b1);
    // Any byte opens a string; then the extreme plain bytes.
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    // High surrogate followed by a plain byte, then by an escape other than \u.
    send_chars("\\uDBFFq");
    send_chars("\\uD800\\x");
    // A pair whose low half is cut short by the end of the text.
    send_chars("\\uD83D\\uDE");
    send_item(8'h00, 1'b1);

    first_random = items_sent;
    strings_sent = 0;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      calm = (strings_sent >= 10 && strings_sent < 20);
      if (strings_sent == 4) hold_wanted = 1'b1;
      if ($urandom_range(9) == 0) send_noise();
      else send_random_string();
      strings_sent++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests in %0d random strings or bursts after the directed cases.",
             items_sent, strings_sent);
    $display("Checked %0d results, %0d of them closing a string.",
             results_checked, strings_closed);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_job_fifo.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8_top.sv
bench/unescape_checker.sv
bench/tb.sv
